/* rtl/pfba_pkg.sv */
// Shared types and codes for the page frame bitmap allocator.
package pfba_pkg;

    localparam logic [32:0] ADDR_SPACE = 33'h1_0000_0000;
    localparam logic [31:0] WORD_ALL_USED = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_RESERVE_RANGE = 2'd0,
        MODE_FREE_RANGE    = 2'd1,
        MODE_ALLOC_PAGE    = 2'd2,
        MODE_FREE_PAGE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_NOMEM   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_MARK,
        ST_SCAN,
        ST_ALLOC,
        ST_DONE,
        ST_REJECT,
        ST_NOMEM
    } ctrl_state_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_CHECK,
        DP_MARK,
        DP_SCAN,
        DP_ALLOC,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  req_ok;
        logic  hint_empty;
        logic  clear_last;
        logic  mark_last;
        logic  scan_found;
        logic  scan_exhausted;
        logic  out_free;
    } dp_status_t;

endpackage

/* rtl/page_frame_bitmap_allocator.sv */
// Top level of the page frame bitmap allocator.
//
// Physical page allocator with one used bit per page, held in a RAM of
// ceil(PAGE_COUNT/32) words of 32 bits (one page per bit, page 32*w+b at
// word w bit b). After reset the block runs a clearing pass that writes
// every word to all ones (every page reserved); s_tready stays low during
// the pass. Requests are taken one at a time, with s_tuser selecting the
// mode (reserve range, free range, allocate page, free page). An item is
// accepted in the idle state and then goes through the range check. Range
// and free-page requests that pass it read each bitmap word the page span
// touches and write it back marked; allocate scans one word per cycle from
// a lowest-free-word hint up to the word holding the free page, then writes
// that word back. The result is then loaded into the output register and
// the block returns to idle. The hint drops to the first word of a free when
// that word lies below it and rises as scans pass full words, so allocation
// after a recent free is short. The result sits in an output register; a
// new item is taken while it waits for m_tready, but the following result
// holds the block (s_tready low) until that register drains.
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int PAGE_COUNT = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] base_address, [64:32] range_length, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] page_address
    output logic [1:0]  m_tuser    // [1:0] status
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    // sequencer
    pfba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bitmap RAM, walker and result register
    pfba_datapath #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/pfba_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pfba_datapath.sv */
// Datapath: request registers, range check, bitmap RAM, word walker, output register.
module pfba_datapath
    import pfba_pkg::*;
#(
    parameter int PAGE_COUNT = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_status_t  stat,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam int PSHIFT = $clog2(PAGE_BYTES);
    localparam int PW     = ($clog2(PAGE_COUNT) > 6) ? $clog2(PAGE_COUNT) : 6;
    localparam int WAW    = PW - 5;
    localparam int WORDS  = (PAGE_COUNT + 31) / 32;
    localparam logic [63:0] SPAN = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    localparam logic [32:0] MEM_END = (SPAN < 64'(ADDR_SPACE)) ? SPAN[32:0] : ADDR_SPACE;
    localparam logic [WAW:0] WORDS_W   = (WAW + 1)'(WORDS);
    localparam logic [WAW:0] LAST_WORD = (WAW + 1)'(WORDS - 1);
    localparam logic [WAW:0] WORD_STEP = (WAW + 1)'(1);

    mode_t          mode_reg;
    logic [31:0]    base_reg;
    logic [32:0]    len_reg;
    logic [PW-1:0]  first_reg, first_next;
    logic [PW-1:0]  last_reg, last_next;
    logic [WAW:0]   cur_reg, cur_next;
    logic           pend_reg, pend_next;
    logic [WAW-1:0] pend_w_reg;
    logic [WAW:0]   hint_reg, hint_next;
    logic [WAW-1:0] found_w_reg;
    logic [4:0]     found_bit_reg;
    logic [31:0]    found_data_reg;
    logic [31:0]    alloc_addr_reg, alloc_addr_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [31:0]    m_tdata_reg;
    logic [1:0]     m_tuser_reg;

    // range check
    logic [33:0]   end_sum;
    logic          range_ok, free_ok, req_ok;
    logic [32:0]   base_page_wide;
    logic [PW-1:0] first_page;
    logic [33:0]   count_wide;
    logic [PW:0]   last_wide;

    // RAM ports
    logic           ram_we, ram_re;
    logic [WAW-1:0] ram_waddr;
    logic [31:0]    ram_wdata, ram_q;

    // word marking
    logic [4:0]  lo_bit, hi_bit;
    logic [31:0] mark_mask, marked_word;
    logic        q_full;
    logic [4:0]  free_bit;
    logic [63:0] page_byte_wide;

    assign end_sum  = 34'(base_reg) + 34'(len_reg);
    assign range_ok = (len_reg != 33'd0) && (33'(base_reg) < MEM_END)
                      && (end_sum <= 34'(MEM_END));
    assign free_ok  = (base_reg[PSHIFT-1:0] == '0) && (33'(base_reg) < MEM_END);
    assign req_ok   = (mode_reg == MODE_FREE_PAGE) ? free_ok : range_ok;

    assign base_page_wide = 33'(base_reg) >> PSHIFT;
    assign first_page     = base_page_wide[PW-1:0];
    assign count_wide     = (34'(len_reg) + 34'(PAGE_BYTES - 1)) >> PSHIFT;
    assign last_wide      = (PW + 1)'(first_page) + count_wide[PW:0] - (PW + 1)'(1);

    // bits of the pending word that fall inside [first, last]
    assign lo_bit = (pend_w_reg == first_reg[PW-1:5]) ? first_reg[4:0] : 5'd0;
    assign hi_bit = (pend_w_reg == last_reg[PW-1:5]) ? last_reg[4:0] : 5'd31;
    assign mark_mask = (WORD_ALL_USED << lo_bit) & (WORD_ALL_USED >> (5'd31 - hi_bit));
    assign marked_word = (mode_reg == MODE_RESERVE_RANGE) ? (ram_q | mark_mask)
                                                          : (ram_q & ~mark_mask);
    assign q_full = &ram_q;

    always_comb begin
        free_bit = 5'd0;
        for (int b = 31; b >= 0; b--) begin
            if (!ram_q[b]) begin
                free_bit = 5'(b);
            end
        end
    end

    assign page_byte_wide = 64'({found_w_reg, found_bit_reg}) << PSHIFT;

    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = cur_reg[WAW-1:0];
        ram_wdata       = WORD_ALL_USED;
        ram_re          = 1'b0;
        cur_next        = cur_reg;
        pend_next       = 1'b0;
        hint_next       = hint_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        alloc_addr_next = alloc_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (cmd.op)
            DP_CLEAR: begin
                ram_we    = 1'b1;
                cur_next  = cur_reg + WORD_STEP;
                hint_next = WORDS_W;
            end
            DP_LOAD: begin
                alloc_addr_next = '0;
            end
            DP_CHECK: begin
                first_next = first_page;
                last_next  = (mode_reg == MODE_FREE_PAGE) ? first_page : last_wide[PW-1:0];
                if (mode_reg == MODE_ALLOC_PAGE) begin
                    cur_next = hint_reg;
                end else begin
                    cur_next = {1'b0, first_page[PW-1:5]};
                end
                if (req_ok && (mode_reg == MODE_FREE_RANGE || mode_reg == MODE_FREE_PAGE)
                        && ({1'b0, first_page[PW-1:5]} < hint_reg)) begin
                    hint_next = {1'b0, first_page[PW-1:5]};
                end
            end
            DP_MARK: begin
                if (cur_reg <= {1'b0, last_reg[PW-1:5]}) begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    cur_next  = cur_reg + WORD_STEP;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_w_reg;
                    ram_wdata = marked_word;
                end
            end
            DP_SCAN: begin
                if (cur_reg < WORDS_W) begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    cur_next  = cur_reg + WORD_STEP;
                end
                if (pend_reg && !q_full) begin
                    hint_next = {1'b0, pend_w_reg};
                end else if (pend_reg && !(cur_reg < WORDS_W)) begin
                    hint_next = WORDS_W;
                end
            end
            DP_ALLOC: begin
                ram_we          = 1'b1;
                ram_waddr       = found_w_reg;
                ram_wdata       = found_data_reg;
                alloc_addr_next = page_byte_wide[31:0];
            end
            DP_OUT: begin
                m_tvalid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg      <= '0;
            pend_reg     <= 1'b0;
            hint_reg     <= WORDS_W;
            m_tvalid_reg <= 1'b0;
        end else begin
            cur_reg      <= cur_next;
            pend_reg     <= pend_next;
            hint_reg     <= hint_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_LOAD) begin
            mode_reg <= mode_t'(s_tuser);
            base_reg <= s_tdata[31:0];
            len_reg  <= s_tdata[64:32];
        end
        first_reg      <= first_next;
        last_reg       <= last_next;
        pend_w_reg     <= cur_reg[WAW-1:0];
        alloc_addr_reg <= alloc_addr_next;
        if (cmd.op == DP_SCAN && pend_reg && !q_full) begin
            found_w_reg    <= pend_w_reg;
            found_bit_reg  <= free_bit;
            found_data_reg <= ram_q | (32'd1 << free_bit);
        end
        if (cmd.op == DP_OUT) begin
            m_tdata_reg <= alloc_addr_reg;
            m_tuser_reg <= cmd.code;
        end
    end

    pfba_ram #(
        .WIDTH (32),
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_reg[WAW-1:0]),
        .rdata (ram_q)
    );

    assign stat.mode           = mode_reg;
    assign stat.req_ok         = req_ok;
    assign stat.hint_empty     = (hint_reg >= WORDS_W);
    assign stat.clear_last     = (cur_reg == LAST_WORD);
    assign stat.mark_last      = (cur_reg > {1'b0, last_reg[PW-1:5]});
    assign stat.scan_found     = pend_reg && !q_full;
    assign stat.scan_exhausted = pend_reg && q_full && !(cur_reg < WORDS_W);
    assign stat.out_free       = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/pfba_ctrl.sv */
// Controller state machine: sequences clear sweep, range check, marking and scanning.
module pfba_ctrl
    import pfba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.mode == MODE_ALLOC_PAGE) begin
                    state_next = stat.hint_empty ? ST_NOMEM : ST_SCAN;
                end else begin
                    state_next = stat.req_ok ? ST_MARK : ST_REJECT;
                end
            end
            ST_MARK: begin
                if (stat.mark_last) state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (stat.scan_found) begin
                    state_next = ST_ALLOC;
                end else if (stat.scan_exhausted) begin
                    state_next = ST_NOMEM;
                end
            end
            ST_ALLOC: begin
                state_next = ST_DONE;
            end
            ST_DONE, ST_REJECT, ST_NOMEM: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.op   = DP_NOP;
        cmd.code = STAT_DONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.op = DP_CLEAR;
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = DP_LOAD;
            end
            ST_CHECK: cmd.op = DP_CHECK;
            ST_MARK:  cmd.op = DP_MARK;
            ST_SCAN:  cmd.op = DP_SCAN;
            ST_ALLOC: cmd.op = DP_ALLOC;
            ST_DONE: begin
                if (stat.out_free) cmd.op = DP_OUT;
                cmd.code = STAT_DONE;
            end
            ST_REJECT: begin
                if (stat.out_free) cmd.op = DP_OUT;
                cmd.code = STAT_INVALID;
            end
            ST_NOMEM: begin
                if (stat.out_free) cmd.op = DP_OUT;
                cmd.code = STAT_NOMEM;
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/pfba_checker.sv */
// Port-level checker for the page frame bitmap allocator, with its bind.
module pfba_assert
    import pfba_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one request at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("back-to-back accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_DONE || m_tuser == STAT_INVALID
                      || m_tuser == STAT_NOMEM))
        else $error("undefined status code");

    // only a completed request can carry an address
    a_addr_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_DONE) |-> (m_tdata == 32'd0))
        else $error("nonzero address on failed request");

endmodule

bind page_frame_bitmap_allocator pfba_assert u_pfba_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* bench/pfba_checker.sv */
// Watches both channels of the allocator, predicts each answer and compares.
`timescale 1ns / 1ps

module pfba_checker
    import pfba_pkg::*;
#(
    parameter int PAGE_COUNT = 65536,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // [31:0] base_address, [64:32] range_length, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] page_address
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          answers_outstanding
);

    typedef struct packed {
        logic [31:0] page_address;
        status_t     status;
    } alloc_answer_t;

    localparam int MAP_WORDS = (PAGE_COUNT + 31) / 32;
    localparam longint unsigned MEM_SPAN = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    localparam longint unsigned MEM_END =
        (MEM_SPAN < 64'(ADDR_SPACE)) ? MEM_SPAN : 64'(ADDR_SPACE);

    // own copy of the page bitmap: bit b of word w is page 32*w+b, set = reserved/used
    logic [31:0]   page_map [MAP_WORDS];
    alloc_answer_t answers_due [$];
    alloc_answer_t oldest;

    function automatic void set_page(longint unsigned page, logic used);
        if (page < PAGE_COUNT)
            page_map[page >> 5][page & 31] = used;
    endfunction

    function automatic alloc_answer_t serve_request(mode_t mode, logic [31:0] base,
                                                    logic [32:0] len);
        alloc_answer_t   ans;
        longint unsigned b64;
        longint unsigned l64;
        longint unsigned first;
        longint unsigned count;
        longint unsigned page;
        logic [31:0]     free_bits;
        logic            found;
        ans.page_address = '0;
        ans.status       = STAT_DONE;
        b64 = 64'(base);
        l64 = 64'(len);
        found = 1'b0;
        case (mode)
            MODE_RESERVE_RANGE, MODE_FREE_RANGE: begin
                if (l64 == 0 || b64 >= MEM_END || b64 + l64 > MEM_END) begin
                    ans.status = STAT_INVALID;
                end else begin
                    // unaligned base keeps its own page, length rounds up
                    first = b64 / PAGE_BYTES;
                    count = (l64 + PAGE_BYTES - 1) / PAGE_BYTES;
                    for (longint unsigned i = 0; i < count; i++)
                        set_page(first + i, mode == MODE_RESERVE_RANGE);
                end
            end
            MODE_ALLOC_PAGE: begin
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    free_bits = ~page_map[w];
                    for (int b = 0; b < 32 && !found; b++) begin
                        page = 64'(w) * 32 + 64'(b);
                        if (page < PAGE_COUNT && free_bits[b]) begin
                            set_page(page, 1'b1);
                            ans.page_address = 32'(page * PAGE_BYTES);
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                    ans.status = STAT_NOMEM;
            end
            default: begin
                if (b64 % PAGE_BYTES != 0 || b64 >= MEM_END)
                    ans.status = STAT_INVALID;
                else
                    set_page(b64 / PAGE_BYTES, 1'b0);
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (page_map[w])
                page_map[w] = WORD_ALL_USED;
            answers_due.delete();
            fail_count = 0;
        end else begin
            // results first: one accepted in the same cycle as a request is older than it
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("unrequested result", m_tdata, '0);
                end else begin
                    oldest = answers_due.pop_front();
                    if (m_tdata !== oldest.page_address)
                        report_mismatch("page_address", m_tdata, oldest.page_address);
                    if (m_tuser !== oldest.status)
                        report_mismatch("status", 32'(m_tuser), 32'(oldest.status));
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(serve_request(mode_t'(s_tuser), s_tdata[31:0],
                                                    s_tdata[64:32]));
        end
        answers_outstanding <= answers_due.size();
    end

endmodule

/* bench/tb_page_frame_bitmap_allocator.sv */
// Top of the allocator bench: clock, reset, request stimulus, stall control, verdict.
`timescale 1ns / 1ps

module tb_page_frame_bitmap_allocator
    import pfba_pkg::*;
();

    localparam int PAGE_COUNT = 65536;
    localparam int PAGE_BYTES = 4096;
    localparam longint unsigned MEM_SPAN = 64'(PAGE_COUNT) * 64'(PAGE_BYTES);
    // first byte past usable memory, 33 bits so 4 GiB still fits
    localparam logic [32:0] MEM_END =
        (MEM_SPAN < 64'(ADDR_SPACE)) ? 33'(MEM_SPAN) : ADDR_SPACE;
    localparam logic [32:0] PAGE_LEN = 33'(PAGE_BYTES);

    localparam int WINDOW_PAGES = 256;   // low pages most traffic lands in (8 bitmap words)
    localparam int TOP_PAGES    = 64;    // pages just below the end of memory
    localparam int PHASE_ITEMS  = 225;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block
    localparam int TAIL_CYCLES  = 64;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // [31:0] base_address, [64:32] range_length, rest zero
    logic [1:0]  s_tuser  = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] page_address
    logic [1:0]  m_tuser;         // [1:0] status

    int fail_count;
    int answers_outstanding;

    // idle/stall knobs, percent per cycle; set by the stimulus per phase
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // hold-off requests: stimulus bumps the token, the receiver process counts the cycles
    int hold_tokens  = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    page_frame_bitmap_allocator #(
        .PAGE_COUNT(PAGE_COUNT),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    pfba_checker #(
        .PAGE_COUNT(PAGE_COUNT),
        .PAGE_BYTES(PAGE_BYTES)
    ) scoreboard (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .fail_count         (fail_count),
        .answers_outstanding(answers_outstanding)
    );

    // Result side: random stalls, plus a counted hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_tokens != hold_seen) begin
            hold_seen <= hold_tokens;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one item after a random gap; returns right after the accepting edge.
    // tvalid stays high on return so back-to-back items keep it up.
    task automatic send_item(mode_t mode, logic [31:0] base, logic [32:0] len);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, len, base};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    // Random requests. Most traffic stays in a small low window so allocations
    // and frees keep hitting the same bitmap words; a few reach the top of
    // memory, a few are junk, and a very few touch all of memory (slow).
    task automatic run_phase(int n, int tx_pct, int rx_pct, bit hold);
        int          pick;
        int          sub;
        int          page;
        mode_t       mode;
        logic [31:0] base;
        logic [32:0] len;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold)
            hold_tokens++;
        repeat (n) begin
            pick = $urandom_range(99);
            sub  = $urandom_range(9);
            // unused fields still get random content
            base = $urandom;
            len  = {1'($urandom_range(1)), 32'($urandom)};
            if (pick < 30) begin
                mode = MODE_ALLOC_PAGE;
            end else if (pick < 55) begin
                mode = MODE_FREE_PAGE;
                if (sub < 8)
                    base = 32'($urandom_range(WINDOW_PAGES - 1) * PAGE_BYTES);
                else if (sub == 8)
                    base = 32'($urandom_range(PAGE_COUNT - 1) * PAGE_BYTES);
                // else: raw 32-bit address, mostly unaligned or out of range
            end else if (pick < 90) begin
                mode = (pick < 72) ? MODE_FREE_RANGE : MODE_RESERVE_RANGE;
                page = (sub < 9) ? $urandom_range(WINDOW_PAGES - 1)
                                 : PAGE_COUNT - 1 - $urandom_range(TOP_PAGES - 1);
                base = 32'(page * PAGE_BYTES);
                if ($urandom_range(1) == 1)
                    base = base + 32'($urandom_range(PAGE_BYTES - 1));
                // near the top, long lengths run past the end and get rejected
                len = 33'($urandom_range(1, ((sub < 9) ? 16 : 80) * PAGE_BYTES));
            end else if (pick < 98) begin
                mode = mode_t'($urandom_range(1));
                if (sub == 0)
                    len = '0;
            end else begin
                mode = mode_t'($urandom_range(1));
                base = '0;
                len  = MEM_END;
            end
            send_item(mode, base, len);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The block clears its bitmap first; send_item simply waits.
        // Everything reserved after reset: allocate runs out (unused fields at max).
        send_item(MODE_ALLOC_PAGE, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
        send_item(MODE_FREE_PAGE, '0, '0);
        send_item(MODE_ALLOC_PAGE, '0, '0);                      // page 0
        send_item(MODE_ALLOC_PAGE, '0, '0);                      // out of memory again
        // rejected ranges: zero length, base at end, tail past end, 4 GiB from top and from zero
        send_item(MODE_FREE_RANGE, '0, '0);
        send_item(MODE_RESERVE_RANGE, MEM_END[31:0], PAGE_LEN);
        send_item(MODE_FREE_RANGE, MEM_END[31:0] - 32'(PAGE_BYTES), 2 * PAGE_LEN);
        send_item(MODE_FREE_RANGE, 32'hFFFF_FFFF, ADDR_SPACE);
        send_item(MODE_RESERVE_RANGE, '0, ADDR_SPACE);
        // unaligned base, one byte: only the base's own page is freed
        send_item(MODE_FREE_RANGE, 32'(PAGE_BYTES + 5), 33'd1);
        send_item(MODE_ALLOC_PAGE, '0, '0);
        // whole memory free, exactly up to the end
        send_item(MODE_FREE_RANGE, '0, MEM_END);
        send_item(MODE_ALLOC_PAGE, '0, '0);
        send_item(MODE_ALLOC_PAGE, '0, '0);
        // single-page frees: unaligned, at end, far out, already free
        send_item(MODE_FREE_PAGE, 32'(PAGE_BYTES + 1), '0);
        send_item(MODE_FREE_PAGE, MEM_END[31:0], '0);
        send_item(MODE_FREE_PAGE, 32'hFFFF_F000, '0);
        send_item(MODE_FREE_PAGE, 32'(5 * PAGE_BYTES), '0);
        // reserve all, then only the last page comes back: highest address returned
        send_item(MODE_RESERVE_RANGE, '0, MEM_END);
        send_item(MODE_FREE_PAGE, MEM_END[31:0] - 32'(PAGE_BYTES), '0);
        send_item(MODE_ALLOC_PAGE, '0, '0);
        send_item(MODE_ALLOC_PAGE, '0, '0);
        // a partial first page, a span crossing words, an unaligned reserve
        send_item(MODE_FREE_RANGE, 32'h0000_03FF, 33'h0_0000_1C01);
        send_item(MODE_FREE_RANGE, 32'(32 * PAGE_BYTES), 64 * PAGE_LEN);
        send_item(MODE_RESERVE_RANGE, 32'(32 * PAGE_BYTES + 1), 33'd1);

        // Random part, phase by phase; the last one opens with the long hold-off.
        run_phase(PHASE_ITEMS, 0, 0, 1'b0);
        run_phase(PHASE_ITEMS, 85, 0, 1'b0);
        run_phase(PHASE_ITEMS, 0, 85, 1'b0);
        run_phase(PHASE_ITEMS, 12, 12, 1'b0);
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        s_tvalid     <= 1'b0;
        rx_stall_pct = 0;
        // the count seen here is registered and may lag the queue, so wait for an edge before trusting it
        @(posedge aclk);
        while (answers_outstanding != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("** page_frame_bitmap_allocator: PASSED **");
        else
            $display("** page_frame_bitmap_allocator: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (whole-bitmap walks on every item).
    initial begin
        #25_000_000;
        $display("** page_frame_bitmap_allocator: FAILED **");
        $finish;
    end

endmodule
